>>> src/gdn_pkg.sv
// Shared constants and helper functions for the Gregorian day number converter.
package gdn_pkg;

    // Request types carried by req_type.
    localparam logic REQ_TO_NUMBER = 1'b0;
    localparam logic REQ_TO_DATE   = 1'b1;

    // Limits of the valid day number range, years 1 to 9999.
    localparam int NUM_MIN = 306;
    localparam int NUM_MAX = 3652364;

    localparam int DAYS_PER_YEAR = 365;
    localparam int YEAR_MONTH_WRAP = 10;

    // Reciprocal of 25 for arguments below 4096: floor(x / 25) = (x * REC25) >> SH25.
    localparam int SH25 = 16;
    localparam logic [11:0] REC25 = 12'd2622;

    // Year estimate (NUM_SCALE * g + NUM_BIAS) / YEAR_DIV by a 37-bit reciprocal.
    localparam int NUM_SCALE = 10000;
    localparam int NUM_BIAS = 14780;
    localparam int YEAR_DIV = 3652425;
    localparam int YEAR_SH = 58;
    localparam int REC_SPLIT = 19;
    localparam logic [36:0] YEAR_REC =
        37'(((64'd1 << YEAR_SH) + 64'(YEAR_DIV) - 64'd1) / 64'(YEAR_DIV));
    localparam logic [18:0] YEAR_REC_LO = YEAR_REC[18:0];
    localparam logic [17:0] YEAR_REC_HI = YEAR_REC[36:19];

    // Month index constants: (100 * d + MI_BIAS) / MI_STEP.
    localparam int MI_SCALE = 100;
    localparam int MI_BIAS = 52;
    localparam int MI_STEP = 3060;
    localparam int MONTHS = 12;

    // March-based month index of a calendar month, (month + 9) mod 12.
    function automatic logic [3:0] fwd_month_index(input logic [3:0] month);
        logic [4:0] s;
        s = 5'(month) + 5'd9;
        if (s >= 5'd24)
        begin
            s = s - 5'd24;
        end
        else if (s >= 5'd12)
        begin
            s = s - 5'd12;
        end
        return s[3:0];
    endfunction

    // Days from March 1 to the first day of the March-based month.
    function automatic logic [8:0] month_offset(input logic [3:0] mi);
        logic [8:0] r;
        case (mi)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // March-based month index of a day of the year, by comparison with each month start.
    function automatic logic [3:0] month_index(input logic [8:0] ddd);
        logic [15:0] t;
        logic [3:0] mi;
        t = 16'(ddd) * 16'(MI_SCALE) + 16'(MI_BIAS);
        mi = 4'd0;
        for (int k = 1; k < MONTHS; k++)
        begin
            if (t >= 16'(MI_STEP * k))
            begin
                mi = mi + 4'd1;
            end
        end
        return mi;
    endfunction

endpackage

>>> src/gdn_if.sv
// Request and response channel interfaces of the day number converter.
interface gdn_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [21:0] number_in;

    modport source (output valid, req_type, year_in, month_in, day_in, number_in,
                    input ready);
    modport sink (input valid, req_type, year_in, month_in, day_in, number_in,
                  output ready);
endinterface

interface gdn_rsp_if;
    logic        valid;
    logic        ready;
    logic [21:0] number_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic        range_error;

    modport source (output valid, number_out, year_out, month_out, day_out, range_error,
                    input ready);
    modport sink (input valid, number_out, year_out, month_out, day_out, range_error,
                  output ready);
endinterface

>>> src/gregorian_day_number_convert_top.sv
// Nine-stage pipeline converting between Gregorian dates and March-based day numbers.
// An accepted item is registered through stages 1 to 9 in order; stage 9 drives the result port.
// Throughput: one item per cycle unless the output stalls; the depth is set by the 36 x 37 bit
// reciprocal multiply of the year estimate and the leap-year correction that follows it.
// A stalled output holds its item while empty stages upstream still fill.
// Reset (rst_n low, asynchronous) clears every stage valid bit; no result is pending after it.
module gregorian_day_number_convert_top (
    input  logic         clk,
    input  logic         rst_n,
    gdn_req_if.sink      req,
    gdn_rsp_if.source    rsp
);

    localparam int NSTAGE = 9;

    logic [NSTAGE:1] v_reg;
    logic [NSTAGE:1] en;

    // Stage 1
    logic        s1_req_reg;
    logic        s1_neg_reg;
    logic [13:0] s1_fy_reg;
    logic [8:0]  s1_mo_reg;
    logic [5:0]  s1_dm_reg;
    logic [21:0] s1_g_reg;
    logic        s1_gbad_reg;
    logic [35:0] s1_n_reg;
    // Stage 2
    logic        s2_req_reg;
    logic        s2_neg_reg;
    logic [11:0] s2_q4_reg;
    logic [23:0] s2_p25_reg;
    logic [22:0] s2_y365_reg;
    logic [8:0]  s2_mo_reg;
    logic [5:0]  s2_dm_reg;
    logic [21:0] s2_g_reg;
    logic        s2_gbad_reg;
    logic [54:0] s2_pl_reg;
    logic [53:0] s2_ph_reg;
    // Stage 3
    logic        s3_req_reg;
    logic        s3_neg_reg;
    logic [7:0]  s3_q100_reg;
    logic [23:0] s3_sum_reg;
    logic [13:0] s3_yi_reg;
    logic [21:0] s3_g_reg;
    logic        s3_gbad_reg;
    // Stage 4
    logic        s4_req_reg;
    logic        s4_ferr_reg;
    logic [21:0] s4_fnum_reg;
    logic [13:0] s4_y_reg;
    logic [11:0] s4_q4_reg;
    logic [23:0] s4_p25_reg;
    logic [22:0] s4_y365_reg;
    logic [21:0] s4_g_reg;
    logic        s4_gbad_reg;
    // Stage 5
    logic        s5_req_reg;
    logic        s5_ferr_reg;
    logic [21:0] s5_fnum_reg;
    logic [13:0] s5_y_reg;
    logic [7:0]  s5_q100_reg;
    logic [23:0] s5_part_reg;
    logic        s5_leap_reg;
    logic        s5_gbad_reg;
    // Stage 6
    logic        s6_req_reg;
    logic        s6_ferr_reg;
    logic [21:0] s6_fnum_reg;
    logic [13:0] s6_y_reg;
    logic [11:0] s6_ddd_reg;
    logic        s6_leap_reg;
    logic        s6_gbad_reg;
    // Stage 7
    logic        s7_req_reg;
    logic        s7_ferr_reg;
    logic [21:0] s7_fnum_reg;
    logic [13:0] s7_y_reg;
    logic [8:0]  s7_ddd_reg;
    logic        s7_gbad_reg;
    // Stage 8
    logic        s8_req_reg;
    logic        s8_ferr_reg;
    logic [21:0] s8_fnum_reg;
    logic [13:0] s8_y_reg;
    logic [8:0]  s8_ddd_reg;
    logic [3:0]  s8_mi_reg;
    logic        s8_gbad_reg;
    // Stage 9, the output register
    logic [21:0] s9_number_reg;
    logic [13:0] s9_year_reg;
    logic [3:0]  s9_month_reg;
    logic [4:0]  s9_day_reg;
    logic        s9_err_reg;

    // Combinational next values
    logic [3:0]  s1_mi_next;
    logic        s1_wrap_next;
    logic [13:0] s1_fy_next;
    logic [5:0]  s1_dm_next;
    logic        s1_gbad_next;
    logic [23:0] s3_sum_next;
    logic [54:0] s3_prod_next;
    logic [23:0] s4_n_next;
    logic        s4_ferr_next;
    logic [7:0]  s5_q100_next;
    logic        s5_div4_next;
    logic        s5_c100_next;
    logic        s5_leap_next;
    logic [23:0] s6_ddd_next;
    logic [8:0]  s7_ddd_next;
    logic [13:0] s7_y_next;
    logic [8:0]  s9_mo_next;
    logic [8:0]  s9_dd_next;
    logic [3:0]  s9_mm_next;
    logic [13:0] s9_y_next;
    logic        s9_wrap_next;

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb
    begin
        en[NSTAGE] = !v_reg[NSTAGE] || rsp.ready;
        for (int i = NSTAGE - 1; i >= 1; i--)
        begin
            en[i] = !v_reg[i] || en[i + 1];
        end
    end

    assign req.ready = en[1];
    assign rsp.valid = v_reg[NSTAGE];
    assign rsp.number_out = s9_number_reg;
    assign rsp.year_out = s9_year_reg;
    assign rsp.month_out = s9_month_reg;
    assign rsp.day_out = s9_day_reg;
    assign rsp.range_error = s9_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= req.valid;
            end
            for (int i = 2; i <= NSTAGE; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i - 1];
                end
            end
        end
    end

    // Stage 1: March-based month and year, day offset, scaled day number.
    always_comb
    begin
        s1_mi_next = gdn_pkg::fwd_month_index(req.month_in);
        s1_wrap_next = (s1_mi_next >= 4'(gdn_pkg::YEAR_MONTH_WRAP));
        s1_fy_next = req.year_in - 14'(s1_wrap_next);
        s1_dm_next = 6'(req.day_in) - 6'd1;
        s1_gbad_next = (req.number_in < 22'(gdn_pkg::NUM_MIN))
                    || (req.number_in > 22'(gdn_pkg::NUM_MAX));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_req_reg <= req.req_type;
            s1_neg_reg <= s1_wrap_next && (req.year_in == 14'd0);
            s1_fy_reg <= s1_fy_next;
            s1_mo_reg <= gdn_pkg::month_offset(s1_mi_next);
            s1_dm_reg <= s1_dm_next;
            s1_g_reg <= req.number_in;
            s1_gbad_reg <= s1_gbad_next;
            s1_n_reg <= 36'(req.number_in) * 36'(gdn_pkg::NUM_SCALE)
                      + 36'(gdn_pkg::NUM_BIAS);
        end
    end

    // Stage 2: products for the forward leap terms and the two halves of the year estimate.
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_req_reg <= s1_req_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_q4_reg <= s1_fy_reg[13:2];
            s2_p25_reg <= 24'(s1_fy_reg[13:2]) * 24'(gdn_pkg::REC25);
            s2_y365_reg <= 23'(s1_fy_reg) * 23'(gdn_pkg::DAYS_PER_YEAR);
            s2_mo_reg <= s1_mo_reg;
            s2_dm_reg <= s1_dm_reg;
            s2_g_reg <= s1_g_reg;
            s2_gbad_reg <= s1_gbad_reg;
            s2_pl_reg <= 55'(s1_n_reg) * 55'(gdn_pkg::YEAR_REC_LO);
            s2_ph_reg <= 54'(s1_n_reg) * 54'(gdn_pkg::YEAR_REC_HI);
        end
    end

    // Stage 3: forward partial sum; year estimate from the combined product.
    always_comb
    begin
        s3_sum_next = 24'(s2_y365_reg) + 24'(s2_q4_reg) + 24'(s2_mo_reg)
                    + {{18{s2_dm_reg[5]}}, s2_dm_reg};
        s3_prod_next = 55'(s2_ph_reg) + 55'(s2_pl_reg[54:gdn_pkg::REC_SPLIT]);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_req_reg <= s2_req_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_q100_reg <= s2_p25_reg[23:gdn_pkg::SH25];
            s3_sum_reg <= s3_sum_next;
            s3_yi_reg <= s3_prod_next[gdn_pkg::YEAR_SH - gdn_pkg::REC_SPLIT +: 14];
            s3_g_reg <= s2_g_reg;
            s3_gbad_reg <= s2_gbad_reg;
        end
    end

    // Stage 4: forward day number and its range check; inverse leap products.
    always_comb
    begin
        s4_n_next = s3_sum_reg - 24'(s3_q100_reg) + 24'(s3_q100_reg[7:2]);
        s4_ferr_next = s3_neg_reg || s4_n_next[23]
                    || (s4_n_next[22:0] < 23'(gdn_pkg::NUM_MIN))
                    || (s4_n_next[22:0] > 23'(gdn_pkg::NUM_MAX));
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_req_reg <= s3_req_reg;
            s4_ferr_reg <= s4_ferr_next;
            s4_fnum_reg <= s4_ferr_next ? 22'd0 : s4_n_next[21:0];
            s4_y_reg <= s3_yi_reg;
            s4_q4_reg <= s3_yi_reg[13:2];
            s4_p25_reg <= 24'(s3_yi_reg[13:2]) * 24'(gdn_pkg::REC25);
            s4_y365_reg <= 23'(s3_yi_reg) * 23'(gdn_pkg::DAYS_PER_YEAR);
            s4_g_reg <= s3_g_reg;
            s4_gbad_reg <= s3_gbad_reg;
        end
    end

    // Stage 5: century terms of the estimate and whether the year before it is a leap year.
    always_comb
    begin
        s5_q100_next = s4_p25_reg[23:gdn_pkg::SH25];
        s5_div4_next = (s4_y_reg[1:0] == 2'd0);
        s5_c100_next = s5_div4_next && (s4_q4_reg == 12'(s5_q100_next) * 12'd25);
        s5_leap_next = s5_div4_next && (!s5_c100_next || (s5_q100_next[1:0] == 2'd0));
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_req_reg <= s4_req_reg;
            s5_ferr_reg <= s4_ferr_reg;
            s5_fnum_reg <= s4_fnum_reg;
            s5_y_reg <= s4_y_reg;
            s5_q100_reg <= s5_q100_next;
            s5_part_reg <= 24'(s4_g_reg) - 24'(s4_y365_reg) - 24'(s4_q4_reg);
            s5_leap_reg <= s5_leap_next;
            s5_gbad_reg <= s4_gbad_reg;
        end
    end

    // Stage 6: day of the estimated year, possibly negative.
    always_comb
    begin
        s6_ddd_next = s5_part_reg + 24'(s5_q100_reg) - 24'(s5_q100_reg[7:2]);
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_req_reg <= s5_req_reg;
            s6_ferr_reg <= s5_ferr_reg;
            s6_fnum_reg <= s5_fnum_reg;
            s6_y_reg <= s5_y_reg;
            s6_ddd_reg <= s6_ddd_next[11:0];
            s6_leap_reg <= s5_leap_reg;
            s6_gbad_reg <= s5_gbad_reg;
        end
    end

    // Stage 7: an estimate one year too far is stepped back by the length of the year before.
    always_comb
    begin
        if (s6_ddd_reg[11])
        begin
            s7_ddd_next = s6_ddd_reg[8:0] + 9'(gdn_pkg::DAYS_PER_YEAR) + 9'(s6_leap_reg);
            s7_y_next = s6_y_reg - 14'd1;
        end
        else
        begin
            s7_ddd_next = s6_ddd_reg[8:0];
            s7_y_next = s6_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_req_reg <= s6_req_reg;
            s7_ferr_reg <= s6_ferr_reg;
            s7_fnum_reg <= s6_fnum_reg;
            s7_y_reg <= s7_y_next;
            s7_ddd_reg <= s7_ddd_next;
            s7_gbad_reg <= s6_gbad_reg;
        end
    end

    // Stage 8: month index.
    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_req_reg <= s7_req_reg;
            s8_ferr_reg <= s7_ferr_reg;
            s8_fnum_reg <= s7_fnum_reg;
            s8_y_reg <= s7_y_reg;
            s8_ddd_reg <= s7_ddd_reg;
            s8_mi_reg <= gdn_pkg::month_index(s7_ddd_reg);
            s8_gbad_reg <= s7_gbad_reg;
        end
    end

    // Stage 9: calendar month, day and year; the fields that do not apply are zero.
    always_comb
    begin
        s9_mo_next = gdn_pkg::month_offset(s8_mi_reg);
        s9_dd_next = s8_ddd_reg - s9_mo_next + 9'd1;
        s9_wrap_next = (s8_mi_reg >= 4'(gdn_pkg::YEAR_MONTH_WRAP));
        s9_mm_next = s9_wrap_next ? s8_mi_reg - 4'd9 : s8_mi_reg + 4'd3;
        s9_y_next = s8_y_reg + 14'(s9_wrap_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            if (s8_req_reg == gdn_pkg::REQ_TO_NUMBER)
            begin
                s9_number_reg <= s8_fnum_reg;
                s9_year_reg <= 14'd0;
                s9_month_reg <= 4'd0;
                s9_day_reg <= 5'd0;
                s9_err_reg <= s8_ferr_reg;
            end
            else if (s8_gbad_reg)
            begin
                s9_number_reg <= 22'd0;
                s9_year_reg <= 14'd0;
                s9_month_reg <= 4'd0;
                s9_day_reg <= 5'd0;
                s9_err_reg <= 1'b1;
            end
            else
            begin
                s9_number_reg <= 22'd0;
                s9_year_reg <= s9_y_next;
                s9_month_reg <= s9_mm_next;
                s9_day_reg <= s9_dd_next[4:0];
                s9_err_reg <= 1'b0;
            end
        end
    end

endmodule

>>> src/gdn_checker.sv
// Port-level checks on the day number converter's result channel, bound to the top level.
module gdn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [21:0] number_out,
    input logic [13:0] year_out,
    input logic [3:0]  month_out,
    input logic [4:0]  day_out,
    input logic        range_error
);

    // A result waiting for the sink keeps its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(number_out) && $stable(year_out)
            && $stable(month_out) && $stable(day_out) && $stable(range_error))
        else $error("result changed while stalled");

    // An error result carries no date and no day number.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && range_error |-> number_out == 22'd0 && year_out == 14'd0
            && month_out == 4'd0 && day_out == 5'd0)
        else $error("error result with non-zero fields");

    // A day number result has no date fields.
    a_fwd_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !range_error && number_out != 22'd0 |->
            year_out == 14'd0 && month_out == 4'd0 && day_out == 5'd0)
        else $error("day number result with date fields");

    // A date result names a real month and a day from one onwards.
    a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !range_error && number_out == 22'd0 |->
            month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1 && year_out >= 14'd1)
        else $error("date result out of range");

    // No result is offered while reset is held.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

endmodule

bind gregorian_day_number_convert_top gdn_checker u_gdn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .number_out  (rsp.number_out),
    .year_out    (rsp.year_out),
    .month_out   (rsp.month_out),
    .day_out     (rsp.day_out),
    .range_error (rsp.range_error)
);

>>> verif/gregorian_day_number_convert_top_tb.sv
// Self-checking testbench for the Gregorian date and day number converter.
`timescale 1ns / 1ps

module gregorian_day_number_convert_top_tb;

    localparam int   IDLE_LIMIT    = 2000;
    localparam int   DRAIN_CYCLES  = 20;
    localparam int   REPORT_LIMIT  = 10;
    localparam int   LONG_STALL    = 150;

    typedef struct packed {
        logic        req_type;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] number;
    } conv_request_t;

    typedef struct packed {
        logic [21:0] number;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        range_error;
    } conv_result_t;

    logic clk;
    logic rst_n;

    gdn_req_if req_ch ();
    gdn_rsp_if rsp_ch ();

    gregorian_day_number_convert_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    conv_result_t awaited_conversions [$];
    int           mismatch_count;
    int           to_number_count;
    int           to_date_count;
    int           flagged_count;
    int           stall_request;
    bit           sender_gaps;
    bit           receiver_gaps;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Day number of March 1 of a March-based year; division truncates as in integer C.
    function automatic longint days_to_year(input longint y);
        return 365 * y + y / 4 - y / 100 + y / 400;
    endfunction

    function automatic longint march_month_start(input longint mi);
        return (mi * 306 + 5) / 10;
    endfunction

    function automatic conv_result_t convert_calendar(input conv_request_t rq);
        conv_result_t r;
        longint       mi;
        longint       y;
        longint       n;
        longint       ddd;
        longint       mm;
        longint       dd;
        r = '0;
        if (rq.req_type == gdn_pkg::REQ_TO_NUMBER)
        begin
            mi = (longint'(rq.month) + 9) % 12;
            y = longint'(rq.year) - mi / 10;
            n = days_to_year(y) + march_month_start(mi) + longint'(rq.day) - 1;
            if (n < gdn_pkg::NUM_MIN || n > gdn_pkg::NUM_MAX)
            begin
                r.range_error = 1'b1;
            end
            else
            begin
                r.number = n[21:0];
            end
        end
        else
        begin
            n = longint'(rq.number);
            if (n < gdn_pkg::NUM_MIN || n > gdn_pkg::NUM_MAX)
            begin
                r.range_error = 1'b1;
            end
            else
            begin
                y = (10000 * n + 14780) / 3652425;
                if (n - days_to_year(y) < 0)
                begin
                    y = y - 1;
                end
                ddd = n - days_to_year(y);
                mi = (100 * ddd + 52) / 3060;
                mm = (mi + 2) % 12 + 1;
                y = y + (mi + 2) / 12;
                dd = ddd - march_month_start(mi) + 1;
                r.year = y[13:0];
                r.month = mm[3:0];
                r.day = dd[4:0];
            end
        end
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Fields that a request ignores still carry random bits.
    function automatic conv_request_t mk_to_number(input int y, input int m, input int d);
        conv_request_t rq;
        logic [31:0]   raw;
        raw = $urandom;
        rq.req_type = gdn_pkg::REQ_TO_NUMBER;
        rq.year = 14'(y);
        rq.month = 4'(m);
        rq.day = 5'(d);
        rq.number = raw[21:0];
        return rq;
    endfunction

    function automatic conv_request_t mk_to_date(input longint n);
        conv_request_t rq;
        logic [31:0]   raw;
        raw = $urandom;
        rq.req_type = gdn_pkg::REQ_TO_DATE;
        rq.year = raw[13:0];
        rq.month = raw[17:14];
        rq.day = raw[22:18];
        rq.number = n[21:0];
        return rq;
    endfunction

    function automatic conv_request_t random_request();
        conv_request_t rq;
        logic [31:0]   raw;
        int            sel;
        sel = $urandom_range(0, 99);
        raw = $urandom;
        if ($urandom_range(0, 1) == 0)
        begin
            if (sel < 88)
            begin
                rq = mk_to_number($urandom_range(1, 9999), $urandom_range(1, 12),
                                  $urandom_range(1, 31));
            end
            else
            begin
                rq = mk_to_number(raw[13:0], raw[17:14], raw[22:18]);
            end
        end
        else
        begin
            if (sel < 80)
            begin
                rq = mk_to_date($urandom_range(gdn_pkg::NUM_MIN, gdn_pkg::NUM_MAX));
            end
            else if (sel < 85)
            begin
                rq = mk_to_date(gdn_pkg::NUM_MIN - 5 + $urandom_range(0, 10));
            end
            else if (sel < 90)
            begin
                rq = mk_to_date(gdn_pkg::NUM_MAX - 5 + $urandom_range(0, 10));
            end
            else
            begin
                rq = mk_to_date(raw[21:0]);
            end
        end
        return rq;
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $realtime, what);
        end
    endfunction

    // Offers one item, waits for it to be taken and records the result it should give.
    task automatic send_request(input conv_request_t rq);
        int gap;
        gap = sender_gaps ? idle_length() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rq.req_type;
        req_ch.year_in <= rq.year;
        req_ch.month_in <= rq.month;
        req_ch.day_in <= rq.day;
        req_ch.number_in <= rq.number;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        awaited_conversions.push_back(convert_calendar(rq));
        if (rq.req_type == gdn_pkg::REQ_TO_NUMBER)
        begin
            to_number_count++;
        end
        else
        begin
            to_date_count++;
        end
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_conversions.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_field_extremes();
        send_request(mk_to_number(1, 1, 1));
        send_request(mk_to_number(9999, 12, 31));
        send_request(mk_to_number(0, 3, 1));
        send_request(mk_to_number(0, 0, 0));
        send_request(mk_to_number(16383, 15, 31));
        send_request(mk_to_number(1, 0, 1));
        send_request(mk_to_number(1, 13, 1));
        send_request(mk_to_number(5, 14, 0));
        send_request(mk_to_number(1, 2, 28));
        send_request(mk_to_number(2000, 2, 29));
        send_request(mk_to_number(1900, 2, 29));
        send_request(mk_to_number(2024, 4, 31));
        send_request(mk_to_number(400, 3, 1));
        send_request(mk_to_number(9999, 12, 0));
        send_request(mk_to_date(gdn_pkg::NUM_MIN - 1));
        send_request(mk_to_date(gdn_pkg::NUM_MIN));
        send_request(mk_to_date(gdn_pkg::NUM_MAX));
        send_request(mk_to_date(gdn_pkg::NUM_MAX + 1));
        send_request(mk_to_date(0));
        send_request(mk_to_date(22'h3FFFFF));
        send_request(mk_to_date(22'h2AAAAA));
        send_request(mk_to_date(22'h155555));
        // Leap day of a 400-year, then the day after it and the leap day again as the day before that one.
        send_request(mk_to_date(days_to_year(1999) + 337 + 28));
        send_request(mk_to_date(days_to_year(2000)));
        send_request(mk_to_date(days_to_year(2000) - 1));
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                receiver_gaps = ($urandom_range(0, 3) != 0);
            end
            send_request(random_request());
        end
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_back_to_back(input int count);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            send_request(random_request());
        end
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // The receiver stops taking results long enough for the pipeline to fill and
    // hold back the sender.
    task automatic test_output_stall(input int count);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        stall_request = LONG_STALL;
        for (int i = 0; i < count; i++)
        begin
            send_request(random_request());
        end
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_drain_pause(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_request(random_request());
        end
        wait_for_results();
        for (int i = 0; i < count; i++)
        begin
            send_request(random_request());
        end
    endtask

    // Dates and day numbers around year starts, leap days and century years.
    task automatic test_year_edges(input int count);
        int     y;
        int     m;
        int     d;
        longint offset;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 11))
                0:       y = 1;
                1:       y = 4;
                2:       y = 100;
                3:       y = 400;
                4:       y = 1600;
                5:       y = 1700;
                6:       y = 1900;
                7:       y = 2000;
                8:       y = 2100;
                9:       y = 9996;
                10:      y = 9999;
                default: y = $urandom_range(1, 9999);
            endcase
            if (i % 2 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       m = 1;
                    1:       m = 2;
                    2:       m = 3;
                    default: m = 12;
                endcase
                case ($urandom_range(0, 4))
                    0:       d = 1;
                    1:       d = 28;
                    2:       d = 29;
                    3:       d = 30;
                    default: d = 31;
                endcase
                send_request(mk_to_number(y, m, d));
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0:       offset = -1;
                    1:       offset = 0;
                    2:       offset = 1;
                    3:       offset = 305;
                    4:       offset = 306;
                    5:       offset = 307;
                    default: offset = 365;
                endcase
                send_request(mk_to_date(days_to_year(y) + offset));
            end
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        to_number_count = 0;
        to_date_count = 0;
        flagged_count = 0;
        stall_request = 0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= gdn_pkg::REQ_TO_NUMBER;
        req_ch.year_in <= '0;
        req_ch.month_in <= '0;
        req_ch.day_in <= '0;
        req_ch.number_in <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_random_traffic(600);
        test_back_to_back(200);
        test_output_stall(40);
        test_drain_pause(20);
        test_year_edges(150);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_conversions.size() != 0)
        begin
            note_mismatch($sformatf("%0d results never arrived", awaited_conversions.size()));
        end
        $display("Converted %0d dates to day numbers and %0d day numbers to dates;",
                 to_number_count, to_date_count);
        $display("%0d out of range.", flagged_count);
        $display("Covered field extremes, month and day overflow, year edges, back-to-back items,");
        $display("a %0d-cycle output stall and a full drain pause; %0d mismatches.",
                 LONG_STALL, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Takes results, compares each with the oldest awaited one and decides ready.
    initial
    begin : result_sink
        conv_result_t got;
        conv_result_t want;
        int           stall_left;
        int           hold_left;
        stall_left = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.number = rsp_ch.number_out;
                got.year = rsp_ch.year_out;
                got.month = rsp_ch.month_out;
                got.day = rsp_ch.day_out;
                got.range_error = rsp_ch.range_error;
                if (got.range_error === 1'b1)
                begin
                    flagged_count++;
                end
                if (awaited_conversions.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result num=%0d %0d-%0d-%0d err=%b",
                                  got.number, got.year, got.month, got.day, got.range_error));
                end
                else
                begin
                    want = awaited_conversions.pop_front();
                    if (got !== want)
                    begin
                        note_mismatch($sformatf(
                            "expected num=%0d %0d-%0d-%0d err=%b, got num=%0d %0d-%0d-%0d err=%b",
                            want.number, want.year, want.month, want.day, want.range_error,
                            got.number, got.year, got.month, got.day, got.range_error));
                    end
                end
            end
            if (stall_request > 0)
            begin
                hold_left = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (receiver_gaps)
                begin
                    stall_left = idle_length();
                end
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Timed out after %0d cycles without an accepted item.", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
src/gdn_pkg.sv
src/gdn_if.sv
src/gregorian_day_number_convert_top.sv
src/gdn_checker.sv
verif/gregorian_day_number_convert_top_tb.sv
